// ===== rtl/texel_to_rgba8888_converter_unit_assert.svh =====
// Assertion macros shared by the texel converter RTL.
// Needs nothing beyond the including module's clock and reset names.
`ifndef TEXEL_TO_RGBA8888_CONVERTER_UNIT_ASSERT_SVH
`define TEXEL_TO_RGBA8888_CONVERTER_UNIT_ASSERT_SVH

// same-cycle implication
`define TXC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("texel converter assertion failed");

// next-cycle implication
`define TXC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("texel converter assertion failed");

`endif

// ===== rtl/texcvt_pkg.sv =====
// Package for the texel to RGBA8888 converter: item types, codes and
// channel scaling tables. No dependencies.
package texcvt_pkg;

    localparam int unsigned PALETTE_DEPTH_DEF = 256;
    localparam int unsigned PAL_INDEX_W       = 8;
    localparam int unsigned PAL_COLOR_W       = 24;
    localparam int unsigned CFG_INDEX_W       = 2;
    localparam int unsigned CFG_DATA_W        = 32;

    localparam logic [31:0] NO_KEY = 32'hffff_ffff;
    localparam logic [7:0]  OPAQUE = 8'hff;

    localparam logic REQ_CONVERT   = 1'b0;
    localparam logic REQ_PAL_WRITE = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_FORMAT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALPHA_BITS   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALPHA_EN     = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_COLOR_KEY    = 2'd3;

    localparam logic [3:0] ABITS_NONE = 4'd0;
    localparam logic [3:0] ABITS_ONE  = 4'd1;
    localparam logic [3:0] ABITS_FOUR = 4'd4;
    localparam logic [3:0] ABITS_EIGHT = 4'd8;

    typedef enum logic [1:0] {
        FMT_PALETTE8 = 2'd0,
        FMT_PACKED16 = 2'd1,
        FMT_RGB24    = 2'd2,
        FMT_BGRA32   = 2'd3
    } t_pix_fmt;

    typedef struct packed {
        logic                   req_type;
        logic [31:0]            pixel_bits;
        logic [PAL_INDEX_W-1:0] palette_index;
        logic [PAL_COLOR_W-1:0] palette_color;
    } t_texel_in;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       status;
    } t_texel_out;

    typedef logic [7:0] t_scale_lut [64];

    // v*255/mask, truncated, found by search so it folds at elaboration
    function automatic t_scale_lut f_scale_lut(int unsigned nbits);
        t_scale_lut  lut;
        int unsigned mask;
        int unsigned num;
        int unsigned q;
        mask = (32'd1 << nbits) - 32'd1;
        for (int unsigned v = 0; v < 64; v++) begin
            num = v * 255;
            q   = 0;
            for (int unsigned k = 0; k < 256; k++) begin
                if (k * mask <= num) begin
                    q = k;
                end
            end
            lut[v] = 8'(q);
        end
        return lut;
    endfunction

    localparam t_scale_lut SCALE_LUT3 = f_scale_lut(3);
    localparam t_scale_lut SCALE_LUT5 = f_scale_lut(5);
    localparam t_scale_lut SCALE_LUT6 = f_scale_lut(6);

endpackage

// ===== rtl/texel_to_rgba8888_converter_unit.sv =====
// Top level of the texel to RGBA8888 converter.
// Depends on texcvt_pkg and texel_to_rgba8888_converter_unit_assert.svh.
//
// Usage:
//   Input channel i_in_valid / o_in_stall / i_in_data carries items of two
//   kinds: convert one texel, or write one palette entry. An item is taken
//   at a clock edge with i_in_valid high and o_in_stall low.
//   Output channel o_out_valid / i_out_stall / o_out_data carries one
//   RGBA result per convert item; palette writes give no result.
//   Throughput is one item per cycle while the output is not stalled. For a
//   convert item, the palette memory's registered read loads at the edge that
//   takes it, and its result then loads into the output register.
//   A palette write lands in memory at the edge that takes it, so the very next
//   convert item sees it. Configuration is written through i_cfg_we / i_cfg_index /
//   i_cfg_data while idle; the user must keep to this, the block does not enforce it.
//   Reset (i_rst_n low, synchronous) empties the pipeline and restores the
//   registers: palette format, no alpha, no color key. Palette contents are
//   undefined until written; no clearing pass is made.
//   When the receiver stalls, the result waits in the output register while
//   one more convert item can enter the read stage; after that o_in_stall
//   rises until the output is taken.
module texel_to_rgba8888_converter_unit #(
    parameter int unsigned PALETTE_DEPTH = texcvt_pkg::PALETTE_DEPTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  texcvt_pkg::t_texel_in                i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output texcvt_pkg::t_texel_out               o_out_data,
    input  logic                                 i_cfg_we,
    input  logic [texcvt_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [texcvt_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

`include "texel_to_rgba8888_converter_unit_assert.svh"

    localparam int unsigned AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int unsigned CW = texcvt_pkg::PAL_INDEX_W + 1;
    localparam logic [CW-1:0] DEPTH_CMP = CW'(PALETTE_DEPTH);

    // configuration
    texcvt_pkg::t_pix_fmt r_pixel_format;
    logic [3:0]           r_alpha_bits;
    logic                 r_alpha_en;
    logic [31:0]          r_color_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_format <= texcvt_pkg::FMT_PALETTE8;
            r_alpha_bits   <= '0;
            r_alpha_en     <= 1'b0;
            r_color_key    <= texcvt_pkg::NO_KEY;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                texcvt_pkg::CFG_PIXEL_FORMAT: begin
                    r_pixel_format <= texcvt_pkg::t_pix_fmt'(i_cfg_data[1:0]);
                end
                texcvt_pkg::CFG_ALPHA_BITS: r_alpha_bits <= i_cfg_data[3:0];
                texcvt_pkg::CFG_ALPHA_EN:   r_alpha_en   <= i_cfg_data[0];
                texcvt_pkg::CFG_COLOR_KEY:  r_color_key  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // handshake
    logic r_s1_valid;
    logic r_out_valid;
    logic out_load;
    logic s1_free;
    logic in_acc;
    logic is_convert;
    logic is_write;

    assign out_load   = !r_out_valid || !i_out_stall;
    assign s1_free    = !r_s1_valid || out_load;
    assign o_in_stall = !s1_free;
    assign in_acc     = i_in_valid && s1_free;
    assign is_convert = in_acc && (i_in_data.req_type == texcvt_pkg::REQ_CONVERT);
    assign is_write   = in_acc && (i_in_data.req_type == texcvt_pkg::REQ_PAL_WRITE);

    // palette memory
    logic [texcvt_pkg::PAL_COLOR_W-1:0] r_palette [PALETTE_DEPTH];
    logic [texcvt_pkg::PAL_COLOR_W-1:0] r_pal_rd;
    logic                               wr_in_range;
    logic                               rd_in_range;

    assign wr_in_range = {1'b0, i_in_data.palette_index} < DEPTH_CMP;
    assign rd_in_range = {1'b0, i_in_data.pixel_bits[7:0]} < DEPTH_CMP;

    always_ff @(posedge i_clk) begin
        if (is_write && wr_in_range) begin
            r_palette[i_in_data.palette_index[AW-1:0]] <= i_in_data.palette_color;
        end
        if (is_convert && rd_in_range) begin
            r_pal_rd <= r_palette[i_in_data.pixel_bits[AW-1:0]];
        end
    end

    // read stage
    logic [31:0] r_s1_pix;
    logic        r_s1_pal_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= is_convert;
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_convert) begin
            r_s1_pix    <= i_in_data.pixel_bits;
            r_s1_pal_ok <= rd_in_range;
        end
    end

    // conversion
    texcvt_pkg::t_texel_out n_out;
    logic [23:0] pal_col;
    logic [15:0] w;
    logic [3:0]  ab;
    logic        key_hit;
    logic [7:0]  kr;
    logic [7:0]  kg;
    logic [7:0]  kb;

    assign pal_col = r_s1_pal_ok ? r_pal_rd : '0;
    assign w       = r_s1_pix[15:0];
    assign ab      = r_alpha_en ? r_alpha_bits : texcvt_pkg::ABITS_NONE;

    always_comb begin
        n_out = '0;
        kr = '0;
        kg = '0;
        kb = '0;
        case (r_pixel_format)
            texcvt_pkg::FMT_PALETTE8: begin
                kr = pal_col[23:16];
                kg = pal_col[15:8];
                kb = pal_col[7:0];
            end
            texcvt_pkg::FMT_RGB24: begin
                kr = r_s1_pix[7:0];
                kg = r_s1_pix[15:8];
                kb = r_s1_pix[23:16];
            end
            default: ;
        endcase
        key_hit = (r_color_key != texcvt_pkg::NO_KEY) && (r_color_key[23:0] == {kr, kg, kb});

        case (r_pixel_format)
            texcvt_pkg::FMT_PALETTE8, texcvt_pkg::FMT_RGB24: begin
                n_out.red   = kr;
                n_out.green = kg;
                n_out.blue  = kb;
                n_out.alpha = key_hit ? 8'h00 : texcvt_pkg::OPAQUE;
            end
            texcvt_pkg::FMT_PACKED16: begin
                case (ab)
                    texcvt_pkg::ABITS_NONE: begin
                        n_out.red   = texcvt_pkg::SCALE_LUT5[{1'b0, w[15:11]}];
                        n_out.green = texcvt_pkg::SCALE_LUT6[w[10:5]];
                        n_out.blue  = texcvt_pkg::SCALE_LUT5[{1'b0, w[4:0]}];
                        n_out.alpha = texcvt_pkg::OPAQUE;
                    end
                    texcvt_pkg::ABITS_ONE: begin
                        n_out.red   = texcvt_pkg::SCALE_LUT5[{1'b0, w[14:10]}];
                        n_out.green = texcvt_pkg::SCALE_LUT5[{1'b0, w[9:5]}];
                        n_out.blue  = texcvt_pkg::SCALE_LUT5[{1'b0, w[4:0]}];
                        n_out.alpha = {8{w[15]}};
                    end
                    texcvt_pkg::ABITS_FOUR: begin
                        n_out.red   = {w[11:8], w[11:8]};
                        n_out.green = {w[7:4], w[7:4]};
                        n_out.blue  = {w[3:0], w[3:0]};
                        n_out.alpha = {w[15:12], w[15:12]};
                    end
                    texcvt_pkg::ABITS_EIGHT: begin
                        n_out.red   = texcvt_pkg::SCALE_LUT3[{3'b000, w[7:5]}];
                        n_out.green = texcvt_pkg::SCALE_LUT3[{3'b000, w[4:2]}];
                        n_out.blue  = {4{w[1:0]}};
                        n_out.alpha = w[15:8];
                    end
                    default: n_out.status = 1'b1;
                endcase
            end
            default: begin
                n_out.blue  = r_s1_pix[7:0];
                n_out.green = r_s1_pix[15:8];
                n_out.red   = r_s1_pix[23:16];
                n_out.alpha = (r_alpha_bits == texcvt_pkg::ABITS_EIGHT) ?
                              r_s1_pix[31:24] : texcvt_pkg::OPAQUE;
            end
        endcase
    end

    // output register
    texcvt_pkg::t_texel_out r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && r_s1_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `TXC_ASSERT_NEXT(a_write_no_result, i_clk, i_rst_n, is_write, !r_s1_valid)
    `TXC_ASSERT_NEXT(a_convert_enters, i_clk, i_rst_n, is_convert, r_s1_valid)
    `TXC_ASSERT_NOW(a_stall_full, i_clk, i_rst_n, o_in_stall,
        r_s1_valid && r_out_valid && i_out_stall)
    `TXC_ASSERT_NOW(a_status_zero, i_clk, i_rst_n, r_out_valid && r_out.status,
        {r_out.red, r_out.green, r_out.blue, r_out.alpha} == 32'd0)
    `TXC_ASSERT_NOW(a_status_fmt, i_clk, i_rst_n, r_out_valid && r_out.status,
        r_pixel_format == texcvt_pkg::FMT_PACKED16)

endmodule

// ===== verif/texel_to_rgba8888_converter_checker.sv =====
// Checker for texel_to_rgba8888_converter_unit: watches the input, output and
// register ports, predicts each RGBA result and compares it field by field.
// Depends on texcvt_pkg.
module texel_to_rgba8888_converter_checker #(
    parameter int unsigned PALETTE_DEPTH = texcvt_pkg::PALETTE_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_stall,
    input  texcvt_pkg::t_texel_in              i_in_data,
    input  logic                               i_out_valid,
    input  logic                               i_out_stall,
    input  texcvt_pkg::t_texel_out             i_out_data,
    input  logic                               i_cfg_we,
    input  logic [texcvt_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [texcvt_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                                 o_fail_count,
    output int                                 o_pending,
    output int                                 o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    texcvt_pkg::t_pix_fmt fmt_q;
    logic [3:0]           alpha_bits_q;
    logic                 alpha_en_q;
    logic [31:0]          color_key_q;

    logic [texcvt_pkg::PAL_COLOR_W-1:0] palette_mem [PALETTE_DEPTH];
    texcvt_pkg::t_texel_out             rgba_expected_q [$];

    int fail_count  = 0;
    int checked     = 0;
    int pending_cnt = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_cnt;
    assign o_checked    = checked;

    task automatic report_mismatch(input string what, input logic [32:0] got,
                                   input logic [32:0] want);
        $display("%0t: mismatch %s: got %0h, expected %0h", $time, what, got, want);
        fail_count++;
    endtask

    function automatic logic [7:0] scale_field(input logic [15:0] word, input int nbits,
                                              input int pos);
        int unsigned mask;
        int unsigned v;
        mask = (32'd1 << nbits) - 32'd1;
        v    = (32'(word) >> pos) & mask;
        return 8'((v * 255) / mask);
    endfunction

    function automatic logic [7:0] key_alpha(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b);
        if (color_key_q != texcvt_pkg::NO_KEY && {r, g, b} == color_key_q[23:0]) begin
            return 8'h00;
        end
        return texcvt_pkg::OPAQUE;
    endfunction

    function automatic texcvt_pkg::t_texel_out convert_texel(input logic [31:0] px);
        texcvt_pkg::t_texel_out             res;
        logic [texcvt_pkg::PAL_COLOR_W-1:0] c;
        logic [15:0]                        w;
        logic [3:0]                         ab;
        int                                 rb;
        int                                 gb;
        int                                 bb;
        res = '0;
        rb  = 1;
        gb  = 1;
        bb  = 1;
        case (fmt_q)
            texcvt_pkg::FMT_PALETTE8: begin
                c = (int'(px[7:0]) < int'(PALETTE_DEPTH)) ? palette_mem[px[7:0]] : '0;
                res.red   = c[23:16];
                res.green = c[15:8];
                res.blue  = c[7:0];
                res.alpha = key_alpha(c[23:16], c[15:8], c[7:0]);
            end
            texcvt_pkg::FMT_PACKED16: begin
                w  = px[15:0];
                ab = alpha_en_q ? alpha_bits_q : texcvt_pkg::ABITS_NONE;
                case (ab)
                    texcvt_pkg::ABITS_NONE: begin
                        rb = 5; gb = 6; bb = 5;
                    end
                    texcvt_pkg::ABITS_ONE: begin
                        rb = 5; gb = 5; bb = 5;
                    end
                    texcvt_pkg::ABITS_FOUR: begin
                        rb = 4; gb = 4; bb = 4;
                    end
                    texcvt_pkg::ABITS_EIGHT: begin
                        rb = 3; gb = 3; bb = 2;
                    end
                    default: begin
                        res.status = 1'b1;
                    end
                endcase
                if (!res.status) begin
                    res.red   = scale_field(w, rb, gb + bb);
                    res.green = scale_field(w, gb, bb);
                    res.blue  = scale_field(w, bb, 0);
                    res.alpha = (ab != texcvt_pkg::ABITS_NONE) ?
                                scale_field(w, int'(ab), rb + gb + bb) : texcvt_pkg::OPAQUE;
                end
            end
            texcvt_pkg::FMT_RGB24: begin
                res.red   = px[7:0];
                res.green = px[15:8];
                res.blue  = px[23:16];
                res.alpha = key_alpha(px[7:0], px[15:8], px[23:16]);
            end
            default: begin
                res.blue  = px[7:0];
                res.green = px[15:8];
                res.red   = px[23:16];
                res.alpha = (alpha_bits_q == texcvt_pkg::ABITS_EIGHT) ?
                            px[31:24] : texcvt_pkg::OPAQUE;
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin : monitor
        texcvt_pkg::t_texel_out want;
        if (!i_rst_n) begin
            fmt_q        = texcvt_pkg::FMT_PALETTE8;
            alpha_bits_q = texcvt_pkg::ABITS_NONE;
            alpha_en_q   = 1'b0;
            color_key_q  = texcvt_pkg::NO_KEY;
            rgba_expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    texcvt_pkg::CFG_PIXEL_FORMAT: begin
                        fmt_q = texcvt_pkg::t_pix_fmt'(i_cfg_data[1:0]);
                    end
                    texcvt_pkg::CFG_ALPHA_BITS: alpha_bits_q = i_cfg_data[3:0];
                    texcvt_pkg::CFG_ALPHA_EN:   alpha_en_q   = i_cfg_data[0];
                    texcvt_pkg::CFG_COLOR_KEY:  color_key_q  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (rgba_expected_q.size() == 0) begin
                    report_mismatch("result with nothing expected", i_out_data, '0);
                end else begin
                    want = rgba_expected_q.pop_front();
                    if (i_out_data.red !== want.red)
                        report_mismatch("red", 33'(i_out_data.red), 33'(want.red));
                    if (i_out_data.green !== want.green)
                        report_mismatch("green", 33'(i_out_data.green), 33'(want.green));
                    if (i_out_data.blue !== want.blue)
                        report_mismatch("blue", 33'(i_out_data.blue), 33'(want.blue));
                    if (i_out_data.alpha !== want.alpha)
                        report_mismatch("alpha", 33'(i_out_data.alpha), 33'(want.alpha));
                    if (i_out_data.status !== want.status)
                        report_mismatch("status", 33'(i_out_data.status), 33'(want.status));
                    checked++;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_in_data.req_type == texcvt_pkg::REQ_PAL_WRITE) begin
                    if (int'(i_in_data.palette_index) < int'(PALETTE_DEPTH)) begin
                        palette_mem[i_in_data.palette_index] = i_in_data.palette_color;
                    end
                end else begin
                    rgba_expected_q.insert(rgba_expected_q.size(),
                                           convert_texel(i_in_data.pixel_bits));
                end
            end
        end
        pending_cnt = rgba_expected_q.size();
    end

endmodule

// ===== verif/tb_texel_to_rgba8888_converter_unit.sv =====
// Testbench top for texel_to_rgba8888_converter_unit: drives texel and palette
// items in bursts under changing register settings and gives the verdict.
// Depends on texcvt_pkg, the unit and texel_to_rgba8888_converter_checker.
module tb_texel_to_rgba8888_converter_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASES      = 20;
    localparam int PHASE_ITEMS = 70;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BLOCK} t_stall_mode;

    logic                               clk       = 1'b0;
    logic                               rst_n     = 1'b0;
    logic                               in_valid  = 1'b0;
    logic                               in_stall;
    texcvt_pkg::t_texel_in              in_data   = '0;
    logic                               out_valid;
    logic                               out_stall = 1'b0;
    texcvt_pkg::t_texel_out             out_data;
    logic                               cfg_we    = 1'b0;
    logic [texcvt_pkg::CFG_INDEX_W-1:0] cfg_index = texcvt_pkg::CFG_PIXEL_FORMAT;
    logic [texcvt_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    int fail_count;
    int pending;
    int checked;

    texcvt_pkg::t_pix_fmt cur_fmt = texcvt_pkg::FMT_PALETTE8;
    logic [31:0] cur_key = texcvt_pkg::NO_KEY;
    bit          written [256];
    int          written_list [$];
    logic [7:0]  keyed_idx;
    bit          have_keyed   = 1'b0;
    int          items_sent   = 0;
    int          settings_cnt = 0;

    t_stall_mode stall_mode  = STALL_NONE;
    int          mode_left   = 100;
    int          stall_phase = 0;

    texel_to_rgba8888_converter_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    texel_to_rgba8888_converter_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always #5 clk = ~clk;

    // receiver back-pressure, switching between patterns
    always @(posedge clk) begin
        if (mode_left == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
            mode_left  <= $urandom_range(40, 300);
        end else begin
            mode_left <= mode_left - 1;
        end
        stall_phase <= (stall_phase == 13) ? 0 : stall_phase + 1;
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
            default:     out_stall <= (stall_phase < 10);
        endcase
    end

    task automatic send_item(input texcvt_pkg::t_texel_in it);
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    task automatic send_convert(input logic [31:0] px);
        texcvt_pkg::t_texel_in it;
        it.req_type      = texcvt_pkg::REQ_CONVERT;
        it.pixel_bits    = px;
        it.palette_index = 8'($urandom());
        it.palette_color = 24'($urandom());
        send_item(it);
    endtask

    task automatic send_palette(input logic [7:0] idx, input logic [23:0] col);
        texcvt_pkg::t_texel_in it;
        it.req_type      = texcvt_pkg::REQ_PAL_WRITE;
        it.pixel_bits    = $urandom();
        it.palette_index = idx;
        it.palette_color = col;
        if (!written[idx]) begin
            written[idx] = 1'b1;
            written_list.insert(written_list.size(), int'(idx));
        end
        send_item(it);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_settings(input texcvt_pkg::t_pix_fmt fmt, input logic [3:0] ab,
                                  input logic ae, input logic [31:0] key);
        logic [31:0] noise;
        drain();
        noise      = $urandom();
        noise[1:0] = fmt;
        cfg_we    <= 1'b1;
        cfg_index <= texcvt_pkg::CFG_PIXEL_FORMAT;
        cfg_data  <= noise;
        @(posedge clk);
        noise      = $urandom();
        noise[3:0] = ab;
        cfg_index <= texcvt_pkg::CFG_ALPHA_BITS;
        cfg_data  <= noise;
        @(posedge clk);
        noise      = $urandom();
        noise[0]   = ae;
        cfg_index <= texcvt_pkg::CFG_ALPHA_EN;
        cfg_data  <= noise;
        @(posedge clk);
        cfg_index <= texcvt_pkg::CFG_COLOR_KEY;
        cfg_data  <= key;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_fmt   = fmt;
        cur_key   = key;
        settings_cnt++;
    endtask

    task automatic send_random_item;
        logic [31:0] px;
        logic [7:0]  idx;
        logic [23:0] col;
        px = $urandom();
        if ($urandom_range(0, 99) < 12) begin
            idx = 8'($urandom());
            col = 24'($urandom());
            if ($urandom_range(0, 4) == 0) begin
                col        = cur_key[23:0];
                keyed_idx  = idx;
                have_keyed = 1'b1;
            end
            send_palette(idx, col);
        end else begin
            case (cur_fmt)
                texcvt_pkg::FMT_PALETTE8: begin
                    if (have_keyed && $urandom_range(0, 5) == 0) begin
                        px[7:0] = keyed_idx;
                    end else if (!written[px[7:0]]) begin
                        px[7:0] = 8'(written_list[$urandom_range(0, written_list.size() - 1)]);
                    end
                end
                texcvt_pkg::FMT_PACKED16: begin
                    case ($urandom_range(0, 9))
                        0: px[15:0] = 16'hffff;
                        1: px[15:0] = 16'h0000;
                        default: ;
                    endcase
                end
                texcvt_pkg::FMT_RGB24: begin
                    if ($urandom_range(0, 5) == 0) begin
                        px[23:0] = {cur_key[7:0], cur_key[15:8], cur_key[23:16]};
                    end
                end
                default: ;
            endcase
            send_convert(px);
        end
    endtask

    function automatic logic [31:0] pick_key;
        case ($urandom_range(0, 4))
            0: return texcvt_pkg::NO_KEY;
            1: return 32'h0000_0000;
            2: return 32'h00ff_ffff;
            3: return {8'hff, 24'($urandom())};
            default: return $urandom();
        endcase
    endfunction

    initial begin
        texcvt_pkg::t_pix_fmt fmt;
        logic [3:0]           ab;
        logic                 ae;
        int                   burst_left;
        int                   gap;
        int                   k;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: palette extremes, overwrite then read, keys, every layout
        write_settings(texcvt_pkg::FMT_PALETTE8, texcvt_pkg::ABITS_NONE, 1'b0,
                       texcvt_pkg::NO_KEY);
        send_palette(8'h00, 24'h000000);
        send_palette(8'hff, 24'hffffff);
        send_palette(8'h5a, 24'h123456);
        send_palette(8'ha5, 24'hfedcba);
        send_convert(32'h0000_0000);
        send_convert(32'hffff_ffff);
        send_convert(32'h0000_005a);
        send_convert(32'h0000_00a5);
        send_palette(8'h5a, 24'h00ff00);
        send_convert(32'h0000_005a);
        write_settings(texcvt_pkg::FMT_PALETTE8, texcvt_pkg::ABITS_NONE, 1'b0, 32'h00ff_ffff);
        send_convert(32'h0000_00ff);
        send_convert(32'h0000_0000);
        write_settings(texcvt_pkg::FMT_RGB24, texcvt_pkg::ABITS_NONE, 1'b0, 32'h0000_0000);
        send_convert(32'hff00_0000);
        send_convert(32'h0056_3412);
        write_settings(texcvt_pkg::FMT_PACKED16, texcvt_pkg::ABITS_EIGHT, 1'b0,
                       texcvt_pkg::NO_KEY);
        send_convert(32'h0000_ffff);
        send_convert(32'h0000_f81f);
        write_settings(texcvt_pkg::FMT_PACKED16, texcvt_pkg::ABITS_ONE, 1'b1, 32'h0000_0000);
        send_convert(32'h0000_7fff);
        write_settings(texcvt_pkg::FMT_PACKED16, texcvt_pkg::ABITS_FOUR, 1'b1,
                       texcvt_pkg::NO_KEY);
        send_convert(32'h0000_f0f0);
        write_settings(texcvt_pkg::FMT_PACKED16, texcvt_pkg::ABITS_EIGHT, 1'b1,
                       texcvt_pkg::NO_KEY);
        send_convert(32'h0000_ff00);
        write_settings(texcvt_pkg::FMT_PACKED16, 4'd15, 1'b1, texcvt_pkg::NO_KEY);
        send_convert(32'h0000_ffff);
        write_settings(texcvt_pkg::FMT_PACKED16, 4'd2, 1'b1, texcvt_pkg::NO_KEY);
        send_convert(32'h0000_1234);
        write_settings(texcvt_pkg::FMT_BGRA32, texcvt_pkg::ABITS_EIGHT, 1'b0,
                       texcvt_pkg::NO_KEY);
        send_convert(32'h80ff_0001);
        write_settings(texcvt_pkg::FMT_BGRA32, texcvt_pkg::ABITS_NONE, 1'b1, 32'h00ff_0001);
        send_convert(32'h80ff_0001);

        // random phases, packed 16-bit visited most since it has the most layouts
        for (int phase = 0; phase < PHASES; phase++) begin
            ae = $urandom_range(0, 1);
            ab = 4'($urandom_range(0, 15));
            case (phase % 5)
                0: fmt = texcvt_pkg::FMT_PALETTE8;
                2: fmt = texcvt_pkg::FMT_RGB24;
                3: begin
                    fmt = texcvt_pkg::FMT_BGRA32;
                    if ($urandom_range(0, 1) == 0) ab = texcvt_pkg::ABITS_EIGHT;
                end
                default: begin
                    fmt = texcvt_pkg::FMT_PACKED16;
                    k   = (phase / 5) * 2 + ((phase % 5) == 4 ? 1 : 0);
                    ae  = 1'b1;
                    case (k)
                        0: ab = texcvt_pkg::ABITS_NONE;
                        1: ab = texcvt_pkg::ABITS_ONE;
                        2: ab = texcvt_pkg::ABITS_FOUR;
                        3: ab = texcvt_pkg::ABITS_EIGHT;
                        4: begin
                            do ab = 4'($urandom_range(0, 15));
                            while (ab == texcvt_pkg::ABITS_NONE || ab == texcvt_pkg::ABITS_ONE ||
                                   ab == texcvt_pkg::ABITS_FOUR ||
                                   ab == texcvt_pkg::ABITS_EIGHT);
                        end
                        5: ae = 1'b0;
                        6: ab = texcvt_pkg::ABITS_FOUR;
                        default: ;
                    endcase
                end
            endcase
            write_settings(fmt, ab, ae, pick_key());
            burst_left = $urandom_range(1, 24);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_random_item();
                burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    if (gap > 0) begin
                        in_valid <= 1'b0;
                        repeat (gap) @(posedge clk);
                    end
                end
                if (n == PHASE_ITEMS / 2) begin
                    drain();
                end
            end
        end

        drain();
        repeat (4) @(posedge clk);
        if (pending != 0) begin
            $display("%0d expected results never arrived", pending);
        end
        $display("sent %0d items under %0d register settings, checked %0d results",
                 items_sent, settings_cnt, checked);
        $display("covered all four formats, every 16-bit layout, bad alpha counts and keys");
        if (fail_count == 0 && pending == 0) begin
            $display("tb_texel_to_rgba8888_converter_unit OK");
        end else begin
            $display("tb_texel_to_rgba8888_converter_unit NOT OK");
        end
        $finish;
    end

    initial begin
        #(2_000_000);
        $display("timeout with %0d results outstanding", pending);
        $display("tb_texel_to_rgba8888_converter_unit NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/texcvt_pkg.sv
rtl/texel_to_rgba8888_converter_unit.sv
verif/texel_to_rgba8888_converter_checker.sv
verif/tb_texel_to_rgba8888_converter_unit.sv
